// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define NFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define NFA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/nfa_pkg.sv =====
`timescale 1ns / 1ps
package nfa_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_PROG  = 2'd1,
        OP_ERASE = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NOPROG = 2'd2,
        ST_LONG   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_MEM,
        BK_CHK,
        BK_LAST,
        BK_CNT_RD,
        BK_CNT_WR,
        BK_CM_RD,
        BK_CM_WR,
        BK_ER_WALK,
        BK_EC_RD,
        BK_EC_WR,
        BK_Q_RD,
        BK_DONE
    } bk_state_t;

    // Classified word handed from front to back.
    typedef struct packed {
        op_t        op;
        logic [3:0] blk;
        logic [3:0] pg;
        logic [7:0] off;
        logic [7:0] data;
        logic       last;
        status_t    st;       // front-end verdict: ok, range or too long
        logic       rf_end;   // range flag of the access after this word
    } cmd_t;

    localparam logic [7:0]  ERASED  = 8'hFF;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    function automatic logic [31:0] sat_inc(input logic [31:0] x);
        sat_inc = (x == CNT_MAX) ? x : x + 32'd1;
    endfunction

endpackage

// ===== src/nfa_if.sv =====
`timescale 1ns / 1ps
interface nfa_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [3:0] block;
    logic [3:0] page;
    logic [7:0] start_offset;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, operation, block, page, start_offset, data_byte,
                    last_byte, input ready);
    modport sink   (input valid, operation, block, page, start_offset, data_byte,
                    last_byte, output ready);
endinterface

interface nfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [1:0]  status;
    logic [31:0] page_reads;
    logic [31:0] page_writes;
    logic [31:0] erase_count;

    modport source (output valid, read_data, status, page_reads, page_writes,
                    erase_count, input ready);
    modport sink   (input valid, read_data, status, page_reads, page_writes,
                    erase_count, output ready);
endinterface

// ===== src/nfa_front.sv =====
`timescale 1ns / 1ps
module nfa_front
    import nfa_pkg::*;
#(
    parameter int BLOCK_COUNT     = 16,
    parameter int PAGES_PER_BLOCK = 16,
    parameter int PAGE_BYTES      = 256,
    parameter int POS_W           = 9
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    nfa_req_if.sink                       req,
    input  logic                          cfg_we,
    input  logic [3:0]                    cfg_wdata,
    input  logic                          busy,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [POS_W+$bits(cmd_t)-1:0] q_data
);

    localparam int BLOCK_BYTES = PAGES_PER_BLOCK * PAGE_BYTES;
    localparam int TOTAL_BYTES = BLOCK_COUNT * BLOCK_BYTES;
    localparam int LIN_W       = $clog2(TOTAL_BYTES + PAGE_BYTES + 256);

    logic [3:0]       rsv_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             rf_reg, rf_next;

    logic             sok, eok, qok, long_acc, in_rng;
    logic [LIN_W-1:0] lin;
    op_t              op;
    cmd_t             cmd;

    assign op = op_t'(req.operation);

    always_comb
    begin
        sok = (32'(req.block) < BLOCK_COUNT) && (32'(req.page) < PAGES_PER_BLOCK)
              && (req.block >= rsv_reg);
        eok = (32'(req.block) < BLOCK_COUNT) && (req.block >= rsv_reg);
        qok = (32'(req.block) < BLOCK_COUNT) && (32'(req.page) < PAGES_PER_BLOCK);
        lin = LIN_W'(BLOCK_BYTES) * LIN_W'(req.block) + LIN_W'(PAGE_BYTES) * LIN_W'(req.page)
              + LIN_W'(req.start_offset) + LIN_W'(pos_reg);
        in_rng   = sok && (lin < LIN_W'(TOTAL_BYTES));
        long_acc = (pos_reg >= POS_W'(PAGE_BYTES));
    end

    always_comb
    begin
        cmd.op     = op;
        cmd.blk    = req.block;
        cmd.pg     = req.page;
        cmd.off    = req.start_offset;
        cmd.data   = req.data_byte;
        cmd.last   = req.last_byte;
        cmd.rf_end = rf_reg;
        cmd.st     = ST_OK;
        pos_next   = pos_reg;
        rf_next    = rf_reg;
        unique case (op)
            OP_ERASE: cmd.st = eok ? ST_OK : ST_RANGE;
            OP_QUERY: cmd.st = qok ? ST_OK : ST_RANGE;
            default:
            begin
                if (long_acc)
                    cmd.st = ST_LONG;
                else if (!in_rng)
                    cmd.st = ST_RANGE;
                cmd.rf_end = rf_reg || (cmd.st != ST_OK);
                if (req.last_byte)
                begin
                    pos_next = '0;
                    rf_next  = 1'b0;
                end
                else
                begin
                    rf_next = cmd.rf_end;
                    if (!long_acc)
                        pos_next = pos_reg + POS_W'(1);
                end
            end
        endcase
    end

    assign req.ready = !q_full && !busy;
    assign q_push    = req.valid && req.ready;
    assign q_data    = {pos_reg, cmd};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsv_reg <= '0;
            pos_reg <= '0;
            rf_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                rsv_reg <= cfg_wdata;
            if (q_push)
            begin
                pos_reg <= pos_next;
                rf_reg  <= rf_next;
            end
        end
    end

endmodule

// ===== src/nfa_cmd_queue.sv =====
`timescale 1ns / 1ps
module nfa_cmd_queue
#(
    parameter int WIDTH = 40
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg, rptr_reg;
    logic [1:0]       cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign rdata     = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== src/nfa_back.sv =====
`timescale 1ns / 1ps
module nfa_back
    import nfa_pkg::*;
#(
    parameter int BLOCK_COUNT     = 16,
    parameter int PAGES_PER_BLOCK = 16,
    parameter int PAGE_BYTES      = 256,
    parameter int POS_W           = 9
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  logic [POS_W+$bits(cmd_t)-1:0] q_data,
    output logic                          q_pop,
    output logic                          busy,
    nfa_rsp_if.source                     rsp
);

    localparam int BLOCK_BYTES = PAGES_PER_BLOCK * PAGE_BYTES;
    localparam int TOTAL_BYTES = BLOCK_COUNT * BLOCK_BYTES;
    localparam int TOTAL_PAGES = BLOCK_COUNT * PAGES_PER_BLOCK;
    localparam int ADDR_W      = $clog2(TOTAL_BYTES);
    localparam int PIDX_W      = $clog2(TOTAL_PAGES);
    localparam int SIDX_W      = $clog2(PAGE_BYTES);

    bk_state_t state_reg, state_next;
    cmd_t      cur_reg, cur_next, q_cmd;
    logic [POS_W-1:0]  pos_reg, pos_next, q_pos;
    logic [ADDR_W-1:0] walk_reg, walk_next;
    logic              pf_reg, pf_next;
    logic [7:0]        res_rd_reg, res_rd_next;
    status_t           res_st_reg, res_st_next;

    logic              out_vld_reg;
    logic [7:0]        out_rd_reg;
    logic [1:0]        out_st_reg;
    logic [31:0]       out_rc_reg, out_wc_reg, out_ec_reg;
    logic              out_load;

    // memories
    logic [7:0]  flash_mem [TOTAL_BYTES];
    logic [31:0] rc_mem [TOTAL_PAGES];
    logic [31:0] wc_mem [TOTAL_PAGES];
    logic [31:0] ec_mem [TOTAL_PAGES];
    logic [7:0]  stage_mem [PAGE_BYTES];

    logic [7:0]        flash_rd_reg, stage_rd_reg;
    logic [31:0]       rc_rd_reg, wc_rd_reg, ec_rd_reg;

    logic              fl_we, fl_re;
    logic [ADDR_W-1:0] fl_waddr, fl_raddr;
    logic [7:0]        fl_wdata;
    logic              rc_we, wc_we, ec_we, cnt_re;
    logic [PIDX_W-1:0] cnt_addr;
    logic [31:0]       cnt_wdata;
    logic              st_we, st_re;
    logic [SIDX_W-1:0] st_waddr, st_raddr;
    logic [7:0]        st_wdata;

    logic [ADDR_W-1:0] item_base, blk_base;
    logic [PIDX_W-1:0] item_pidx, blk_pidx;
    logic              out_free, prog_fail;

    assign {q_pos, q_cmd} = q_data;

    assign item_base = ADDR_W'(BLOCK_BYTES) * ADDR_W'(cur_reg.blk)
                       + ADDR_W'(PAGE_BYTES) * ADDR_W'(cur_reg.pg) + ADDR_W'(cur_reg.off);
    assign blk_base  = ADDR_W'(BLOCK_BYTES) * ADDR_W'(cur_reg.blk);
    assign item_pidx = PIDX_W'(PAGES_PER_BLOCK) * PIDX_W'(cur_reg.blk) + PIDX_W'(cur_reg.pg);
    assign blk_pidx  = PIDX_W'(PAGES_PER_BLOCK) * PIDX_W'(cur_reg.blk) + PIDX_W'(walk_reg);
    assign out_free  = !out_vld_reg || rsp.ready;
    assign prog_fail = |(cur_reg.data & ~flash_rd_reg);
    assign busy      = (state_reg == BK_CLEAR);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR:
                if (walk_reg == ADDR_W'(TOTAL_BYTES - 1))
                    state_next = BK_IDLE;
            BK_IDLE:
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_ERASE: state_next = (q_cmd.st == ST_OK) ? BK_ER_WALK : BK_DONE;
                        OP_QUERY: state_next = (q_cmd.st == ST_OK) ? BK_Q_RD : BK_DONE;
                        default:
                            priority if (q_cmd.st == ST_OK)
                                state_next = BK_MEM;
                            else if (q_cmd.last)
                                state_next = BK_LAST;
                            else
                                state_next = BK_DONE;
                    endcase
                end
            BK_MEM:    state_next = BK_CHK;
            BK_CHK:    state_next = cur_reg.last ? BK_LAST : BK_DONE;
            BK_LAST:   state_next = cur_reg.rf_end ? BK_DONE : BK_CNT_RD;
            BK_CNT_RD: state_next = BK_CNT_WR;
            BK_CNT_WR:
                state_next = (cur_reg.op == OP_PROG && !pf_reg) ? BK_CM_RD : BK_DONE;
            BK_CM_RD:  state_next = BK_CM_WR;
            BK_CM_WR:
                state_next = (walk_reg == ADDR_W'(pos_reg)) ? BK_DONE : BK_CM_RD;
            BK_ER_WALK:
                if (walk_reg == ADDR_W'(BLOCK_BYTES - 1))
                    state_next = BK_EC_RD;
            BK_EC_RD:  state_next = BK_EC_WR;
            BK_EC_WR:
                state_next = (walk_reg == ADDR_W'(PAGES_PER_BLOCK - 1)) ? BK_DONE : BK_EC_RD;
            BK_Q_RD:   state_next = BK_DONE;
            BK_DONE:
                if (out_free)
                    state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        q_pop       = 1'b0;
        cur_next    = cur_reg;
        pos_next    = pos_reg;
        walk_next   = walk_reg;
        pf_next     = pf_reg;
        res_rd_next = res_rd_reg;
        res_st_next = res_st_reg;
        out_load    = 1'b0;
        fl_we       = 1'b0;
        fl_re       = 1'b0;
        fl_waddr    = item_base + walk_reg;
        fl_raddr    = item_base + ADDR_W'(pos_reg);
        fl_wdata    = stage_rd_reg;
        rc_we       = 1'b0;
        wc_we       = 1'b0;
        ec_we       = 1'b0;
        cnt_re      = 1'b0;
        cnt_addr    = item_pidx;
        cnt_wdata   = '0;
        st_we       = 1'b0;
        st_re       = 1'b0;
        st_waddr    = pos_reg[SIDX_W-1:0];
        st_raddr    = walk_reg[SIDX_W-1:0];
        st_wdata    = flash_rd_reg;
        unique case (state_reg)
            BK_CLEAR:
            begin
                fl_we     = 1'b1;
                fl_waddr  = walk_reg;
                fl_wdata  = ERASED;
                cnt_addr  = walk_reg[PIDX_W-1:0];
                if (32'(walk_reg) < TOTAL_PAGES)
                begin
                    rc_we = 1'b1;
                    wc_we = 1'b1;
                    ec_we = 1'b1;
                end
                walk_next = (walk_reg == ADDR_W'(TOTAL_BYTES - 1)) ? '0 : walk_reg + ADDR_W'(1);
            end
            BK_IDLE:
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    cur_next    = q_cmd;
                    pos_next    = q_pos;
                    walk_next   = '0;
                    res_rd_next = '0;
                    res_st_next = q_cmd.st;
                end
            BK_MEM:
                fl_re = 1'b1;
            BK_CHK:
                if (cur_reg.op == OP_READ)
                begin
                    res_rd_next = flash_rd_reg;
                    st_we       = 1'b1;
                end
                else if (prog_fail)
                begin
                    res_st_next = ST_NOPROG;
                    pf_next     = 1'b1;
                end
                else
                begin
                    st_we    = 1'b1;
                    st_wdata = cur_reg.data;
                end
            BK_LAST:
            begin
                if (res_st_reg == ST_OK)
                begin
                    priority if (cur_reg.rf_end)
                        res_st_next = ST_RANGE;
                    else if (pf_reg)
                        res_st_next = ST_NOPROG;
                end
                if (cur_reg.rf_end)
                    pf_next = 1'b0;
            end
            BK_CNT_RD:
                cnt_re = 1'b1;
            BK_CNT_WR:
            begin
                if (cur_reg.op == OP_READ)
                begin
                    rc_we     = 1'b1;
                    cnt_wdata = sat_inc(rc_rd_reg);
                end
                else
                begin
                    wc_we     = 1'b1;
                    cnt_wdata = sat_inc(wc_rd_reg);
                end
                if (!(cur_reg.op == OP_PROG && !pf_reg))
                    pf_next = 1'b0;
            end
            BK_CM_RD:
                st_re = 1'b1;
            BK_CM_WR:
            begin
                fl_we     = 1'b1;
                walk_next = walk_reg + ADDR_W'(1);
            end
            BK_ER_WALK:
            begin
                fl_we     = 1'b1;
                fl_waddr  = blk_base + walk_reg;
                fl_wdata  = ERASED;
                walk_next = (walk_reg == ADDR_W'(BLOCK_BYTES - 1)) ? '0 : walk_reg + ADDR_W'(1);
            end
            BK_EC_RD:
            begin
                cnt_re   = 1'b1;
                cnt_addr = blk_pidx;
            end
            BK_EC_WR:
            begin
                ec_we     = 1'b1;
                cnt_addr  = blk_pidx;
                cnt_wdata = sat_inc(ec_rd_reg);
                walk_next = walk_reg + ADDR_W'(1);
            end
            BK_Q_RD:
                cnt_re = 1'b1;
            BK_DONE:
                out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fl_we)
            flash_mem[fl_waddr] <= fl_wdata;
        if (fl_re)
            flash_rd_reg <= flash_mem[fl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rc_we)
            rc_mem[cnt_addr] <= cnt_wdata;
        if (wc_we)
            wc_mem[cnt_addr] <= cnt_wdata;
        if (ec_we)
            ec_mem[cnt_addr] <= cnt_wdata;
        if (cnt_re)
        begin
            rc_rd_reg <= rc_mem[cnt_addr];
            wc_rd_reg <= wc_mem[cnt_addr];
            ec_rd_reg <= ec_mem[cnt_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            stage_mem[st_waddr] <= st_wdata;
        if (st_re)
            stage_rd_reg <= stage_mem[st_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_CLEAR;
            walk_reg    <= '0;
            pf_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            pf_reg    <= pf_next;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (rsp.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        pos_reg    <= pos_next;
        res_rd_reg <= res_rd_next;
        res_st_reg <= res_st_next;
        if (out_load)
        begin
            out_rd_reg <= res_rd_reg;
            out_st_reg <= res_st_reg;
            if (cur_reg.op == OP_QUERY && cur_reg.st == ST_OK)
            begin
                out_rc_reg <= rc_rd_reg;
                out_wc_reg <= wc_rd_reg;
                out_ec_reg <= ec_rd_reg;
            end
            else
            begin
                out_rc_reg <= '0;
                out_wc_reg <= '0;
                out_ec_reg <= '0;
            end
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.read_data   = out_rd_reg;
    assign rsp.status      = out_st_reg;
    assign rsp.page_reads  = out_rc_reg;
    assign rsp.page_writes = out_wc_reg;
    assign rsp.erase_count = out_ec_reg;

endmodule

// ===== src/nor_flash_array_model.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                                              Handshake
// req       in   operation, block, page, start_offset, data_byte,      valid/ready
//                last_byte
// rsp       out  read_data, status, page_reads, page_writes,          valid/ready
//                erase_count
// cfg       in   cfg_wdata = reserved_blocks                           cfg_we
//
// Per word: a read or program byte in range reads and checks the flash, out of
// range it goes straight to the response; a last byte adds the counter
// read-modify-write when the access counts; a program commit copies each staged
// byte back to the flash. Erase walks the block's bytes, then bumps the erase
// counter of each page in it; query reads the counters of one page.
// Reset: req.ready stays low while the array is filled with 0xFF and the
// counters are zeroed.
// Stalls: the front classifies into a 2-deep queue; a stalled rsp holds the back
// end until its output register is taken, and the front too once the queue is full.
module nor_flash_array_model
    import nfa_pkg::*;
#(
    parameter int BLOCK_COUNT     = 16,
    parameter int PAGES_PER_BLOCK = 16,
    parameter int PAGE_BYTES      = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    nfa_req_if.sink    req,
    nfa_rsp_if.source  rsp,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata
);

    // access position runs 0..PAGE_BYTES
    localparam int POS_W = $clog2(PAGE_BYTES + 1);
    localparam int QW    = POS_W + $bits(cmd_t);

    logic          busy, q_full, q_push, q_pop, q_valid;
    logic [QW-1:0] q_wdata, q_rdata;

    // front: address checks, access position and range flag
    nfa_front #(
        .BLOCK_COUNT     (BLOCK_COUNT),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
        .PAGE_BYTES      (PAGE_BYTES),
        .POS_W           (POS_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .busy      (busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    nfa_cmd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rdata     (q_rdata)
    );

    // back: memories, program check, commit, erase, counters
    nfa_back #(
        .BLOCK_COUNT     (BLOCK_COUNT),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
        .PAGE_BYTES      (PAGE_BYTES),
        .POS_W           (POS_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .busy    (busy),
        .rsp     (rsp)
    );

endmodule

// ===== src/nfa_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nfa_checker
    import nfa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [31:0] rsp_page_reads,
    input logic [31:0] rsp_page_writes,
    input logic [31:0] rsp_erase_count
);

    `NFA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status), "rsp word changed while stalled")
    `NFA_ASSERT_ALWAYS(a_clear_blocks, !rst_n |=> !req_ready, "req accepted during array clear")
    `NFA_ASSERT(a_counts_ok, rsp_valid && (rsp_page_reads != 32'd0 || rsp_page_writes != 32'd0 || rsp_erase_count != 32'd0) |-> rsp_status == ST_OK, "counts on a failed query")

endmodule

bind nor_flash_array_model nfa_checker u_nfa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_page_reads  (rsp.page_reads),
    .rsp_page_writes (rsp.page_writes),
    .rsp_erase_count (rsp.erase_count)
);

// ===== tb/sv/tb_nor_flash_array_model.sv =====
`timescale 1ns / 1ps
module tb_nor_flash_array_model;
    import nfa_pkg::*;

    localparam int ARRAY_BYTES = 65536;
    localparam int BLK_BYTES   = 4096;
    localparam int PG_BYTES    = 256;
    localparam int PG_PER_BLK  = 16;
    localparam int ITEM_GOAL   = 1150;
    // Reset clear pass plus erases and commits, stalls included, many times over.
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        op_t        op;
        logic [3:0] blk;
        logic [3:0] pg;
        logic [7:0] off;
        logic [7:0] data;
        logic       last;
    } flash_cmd_t;

    typedef struct {
        logic [7:0]  rd;
        status_t     st;
        logic [31:0] rc;
        logic [31:0] wc;
        logic [31:0] ec;
    } flash_rsp_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [3:0] cfg_wdata;

    nfa_req_if req ();
    nfa_rsp_if rsp ();

    nor_flash_array_model DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow of the flash: array contents, per-page counters, open access.
    logic [7:0]  flash_mem [ARRAY_BYTES];
    logic [31:0] rd_cnt [256];
    logic [31:0] wr_cnt [256];
    logic [31:0] er_cnt [256];
    logic [7:0]  stage_buf [PG_BYTES];
    int unsigned acc_pos;
    bit          prog_fail;
    bit          range_fail;
    logic [3:0]  resv_blocks;

    flash_cmd_t pending_words [$];
    flash_rsp_t expected_words [$];

    bit    req_took;
    bit    calm;          // no idling on either side while set
    int    errors;
    int    cycles;
    int    sent_items;
    int    erase_items;
    int    cfg_writes;
    int    status_seen [4];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] count_up(input logic [31:0] x);
        return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

    // Predicted response for one accepted word; updates the shadow.
    task automatic predict_word(input flash_cmd_t w, output flash_rsp_t r);
        int unsigned pos;
        int unsigned base;
        int unsigned idx;
        bit          start_ok;
        logic [7:0]  cur;
        r.rd = 8'd0;
        r.st = ST_OK;
        r.rc = 32'd0;
        r.wc = 32'd0;
        r.ec = 32'd0;
        idx = w.blk * PG_PER_BLK + w.pg;
        case (w.op)
            OP_ERASE:
            begin
                if (w.blk >= resv_blocks)
                begin
                    for (int i = 0; i < BLK_BYTES; i++)
                        flash_mem[w.blk * BLK_BYTES + i] = 8'hFF;
                    for (int p = 0; p < PG_PER_BLK; p++)
                        er_cnt[w.blk * PG_PER_BLK + p] = count_up(er_cnt[w.blk * PG_PER_BLK + p]);
                end
                else
                    r.st = ST_RANGE;
            end
            OP_QUERY:
            begin
                // 4-bit block/page are always inside the 16x16 array; reserved may be queried
                r.rc = rd_cnt[idx];
                r.wc = wr_cnt[idx];
                r.ec = er_cnt[idx];
            end
            default:
            begin
                pos      = acc_pos;
                start_ok = (w.blk >= resv_blocks);
                base     = start_ok ? w.blk * BLK_BYTES + w.pg * PG_BYTES + w.off : 0;
                if (pos >= PG_BYTES)
                begin
                    r.st = ST_LONG;
                    range_fail = 1'b1;
                end
                else if (!start_ok || base + pos >= ARRAY_BYTES)
                begin
                    r.st = ST_RANGE;
                    range_fail = 1'b1;
                end
                else
                begin
                    cur = flash_mem[base + pos];
                    if (w.op == OP_READ)
                    begin
                        r.rd = cur;
                        stage_buf[pos] = cur;
                    end
                    else if ((w.data & ~cur) != 8'd0)
                    begin
                        r.st = ST_NOPROG;
                        prog_fail = 1'b1;
                    end
                    else
                        stage_buf[pos] = w.data;
                end
                if (w.last)
                begin
                    if (!range_fail)
                    begin
                        if (w.op == OP_READ)
                            rd_cnt[idx] = count_up(rd_cnt[idx]);
                        else
                            wr_cnt[idx] = count_up(wr_cnt[idx]);
                        if (w.op == OP_PROG && !prog_fail)
                            for (int i = 0; i <= pos && i < PG_BYTES; i++)
                                if (base + i < ARRAY_BYTES)
                                    flash_mem[base + i] = stage_buf[i];
                    end
                    if (r.st == ST_OK)
                    begin
                        if (range_fail)
                            r.st = ST_RANGE;
                        else if (prog_fail)
                            r.st = ST_NOPROG;
                    end
                    acc_pos    = 0;
                    range_fail = 1'b0;
                    prog_fail  = 1'b0;
                end
                else if (pos < PG_BYTES)
                    acc_pos = pos + 1;
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %0s: got %0h expected %0h (cycle %0d)", field, got, want, cycles);
        errors++;
    endtask

    // Monitor: sample on the rising edge, predict accepted words, check responses.
    always @(posedge clk)
    begin
        flash_rsp_t want;
        flash_cmd_t w;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            if (cfg_we)
                resv_blocks = cfg_wdata;
            req_took = req.valid && req.ready;
            if (req_took)
            begin
                w.op   = op_t'(req.operation);
                w.blk  = req.block;
                w.pg   = req.page;
                w.off  = req.start_offset;
                w.data = req.data_byte;
                w.last = req.last_byte;
                predict_word(w, want);
                expected_words.push_back(want);
            end
            if (rst_n && rsp.valid && rsp.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("unexpected response word (cycle %0d)", cycles);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    status_seen[rsp.status]++;
                    if (rsp.read_data !== want.rd)
                        report_mismatch("read_data", 32'(rsp.read_data), 32'(want.rd));
                    if (rsp.status !== want.st)
                        report_mismatch("status", 32'(rsp.status), 32'(want.st));
                    if (rsp.page_reads !== want.rc)
                        report_mismatch("page_reads", rsp.page_reads, want.rc);
                    if (rsp.page_writes !== want.wc)
                        report_mismatch("page_writes", rsp.page_writes, want.wc);
                    if (rsp.erase_count !== want.ec)
                        report_mismatch("erase_count", rsp.erase_count, want.ec);
                end
            end
        end
    end

    // Driver: change inputs on the falling edge; hold a word until it is taken.
    always @(negedge clk)
    begin
        flash_cmd_t w;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (!req.valid || req_took)
            begin
                if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 23))
                begin
                    w = pending_words.pop_front();
                    req.valid        <= 1'b1;
                    req.operation    <= w.op;
                    req.block        <= w.blk;
                    req.page         <= w.pg;
                    req.start_offset <= w.off;
                    req.data_byte    <= w.data;
                    req.last_byte    <= w.last;
                end
                else
                    req.valid <= 1'b0;
            end
            rsp.ready <= calm || ($urandom_range(99) >= 23);
        end
    end

    // Queue one word.
    task automatic push_word(input op_t op, input int blk, input int pg, input int off,
                             input int data, input bit last);
        flash_cmd_t w;
        w.op   = op;
        w.blk  = 4'(blk);
        w.pg   = 4'(pg);
        w.off  = 8'(off);
        w.data = 8'(data);
        w.last = last;
        pending_words.push_back(w);
        sent_items++;
        if (op == OP_ERASE)
            erase_items++;
    endtask

    // Queue a read or program access of len bytes. Program bytes only clear bits of
    // the current shadow contents unless picked as noise; some reads are mixed in.
    task automatic push_access(input op_t op, input int blk, input int pg, input int off,
                               input int len, input int noise_pct);
        int unsigned addr;
        int          data;
        op_t         o;
        for (int p = 0; p < len; p++)
        begin
            addr = blk * BLK_BYTES + pg * PG_BYTES + off + p;
            o    = op;
            if (op == OP_PROG && $urandom_range(99) < 10)
                o = OP_READ;
            if (addr < ARRAY_BYTES && $urandom_range(99) >= noise_pct)
                data = flash_mem[addr] & $urandom_range(255);
            else
                data = $urandom_range(255);
            push_word(o, blk, pg, off, data, p == len - 1);
        end
    endtask

    // Wait until the block has nothing in flight, then let it settle.
    task automatic drain_all();
        do
            @(negedge clk);
        while (pending_words.size() > 0 || req.valid || expected_words.size() > 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reserved(input int v);
        drain_all();
        cfg_we    <= 1'b1;
        cfg_wdata <= 4'(v);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
        @(negedge clk);
    endtask

    initial
    begin
        int blk;
        int len;
        int r;
        bit long_done;
        req.valid        = 1'b0;
        req.operation    = OP_READ;
        req.block        = 4'd0;
        req.page         = 4'd0;
        req.start_offset = 8'd0;
        req.data_byte    = 8'd0;
        req.last_byte    = 1'b0;
        rsp.ready        = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 4'd0;
        rst_n            = 1'b0;
        calm             = 1'b0;
        long_done        = 1'b0;
        errors = 0; cycles = 0; sent_items = 0; erase_items = 0; cfg_writes = 0;
        req_took = 1'b0;
        acc_pos = 0; prog_fail = 0; range_fail = 0; resv_blocks = 4'd0;
        for (int i = 0; i < ARRAY_BYTES; i++)
            flash_mem[i] = 8'hFF;
        for (int i = 0; i < 256; i++)
        begin
            rd_cnt[i] = 0;
            wr_cnt[i] = 0;
            er_cnt[i] = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: corners of the array, every operation, each status but too long.
        write_reserved(0);
        push_access(OP_READ, 0, 0, 0, 1, 0);
        push_word(OP_PROG, 15, 15, 255, 8'h00, 1'b1);   // very last byte of the array
        push_word(OP_PROG, 15, 15, 255, 8'hFF, 1'b1);   // would set a cleared bit
        push_word(OP_READ, 15, 15, 255, 0, 1'b0);       // run past the end of the array
        push_word(OP_READ, 15, 15, 255, 0, 1'b1);
        push_word(OP_PROG, 3, 7, 128, 8'hA5, 1'b0);     // two-byte program into erased bytes, no bad byte
        push_word(OP_PROG, 3, 7, 128, 8'h00, 1'b1);
        push_word(OP_QUERY, 15, 15, 0, 0, 1'b0);
        push_word(OP_QUERY, 3, 7, 0, 0, 1'b1);
        push_word(OP_ERASE, 15, 0, 0, 0, 1'b0);
        push_word(OP_QUERY, 15, 3, 0, 0, 1'b0);
        push_access(OP_PROG, 0, 0, 250, 12, 0);         // crosses a page border
        drain_all();
        write_reserved(15);
        push_access(OP_READ, 0, 0, 0, 2, 0);            // reserved block
        push_word(OP_ERASE, 14, 0, 0, 0, 1'b1);
        push_word(OP_ERASE, 15, 0, 0, 0, 1'b1);
        push_word(OP_QUERY, 0, 0, 0, 0, 1'b0);          // reserved pages still queryable
        push_access(OP_PROG, 15, 15, 0, 3, 0);
        push_access(OP_READ, 14, 15, 250, 10, 0);        // starts reserved, ends allowed
        drain_all();
        write_reserved(0);

        // Random phases: mostly well-formed accesses; drained between phases.
        for (int ph = 0; sent_items < ITEM_GOAL; ph++)
        begin
            calm = (ph >= 8 && ph < 12);
            if (ph % 4 == 3)
                write_reserved($urandom_range(99) < 70 ? $urandom_range(3)
                                                       : $urandom_range(15));
            for (int k = 0; k < 10; k++)
            begin
                blk = ($urandom_range(99) < 85) ? $urandom_range(15, resv_blocks)
                                                : $urandom_range(15);
                r   = $urandom_range(99);
                len = ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 40);
                if (!long_done && ph == 5)
                begin
                    push_access(OP_READ, 15, 0, $urandom_range(255), 260, 0);
                    long_done = 1'b1;
                end
                else if (r < 35)
                    push_access(OP_READ, blk, $urandom_range(15), $urandom_range(255), len, 0);
                else if (r < 75)
                    push_access(OP_PROG, blk, $urandom_range(15), $urandom_range(255), len,
                                ($urandom_range(99) < 80) ? 0 : 50);
                else if (r < 90)
                    push_word(OP_QUERY, $urandom_range(15), $urandom_range(15),
                              $urandom_range(255), $urandom_range(255), $urandom_range(1));
                else if (r < 93)
                    push_word(OP_ERASE, blk, $urandom_range(15), $urandom_range(255),
                              $urandom_range(255), $urandom_range(1));
                else
                    // noise: any operation, any field values
                    push_word(op_t'($urandom_range(3)), $urandom_range(15), $urandom_range(15),
                              $urandom_range(255), $urandom_range(255), $urandom_range(1));
            end
            drain_all();
        end
        calm = 1'b0;
        drain_all();
        repeat (20) @(posedge clk);

        $display("sent %0d words (%0d erases) over %0d reserved-block settings in %0d cycles",
                 sent_items, erase_items, cfg_writes, cycles);
        $display("status seen: ok %0d, range %0d, no-program %0d, too long %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0 && expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
